// File: design/onb_pkg.sv
package onb_pkg;

    typedef struct packed {
        logic signed [15:0] out_dir_x;
        logic signed [15:0] out_dir_y;
        logic signed [15:0] out_dir_z;
        logic signed [15:0] in_dir_x;
        logic signed [15:0] in_dir_y;
        logic signed [15:0] in_dir_z;
    } t_in;

    typedef struct packed {
        logic [15:0] value_red;
        logic [15:0] value_green;
        logic [15:0] value_blue;
    } t_out;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REFL_RED   = 3'd0,
        CFG_REFL_GREEN = 3'd1,
        CFG_REFL_BLUE  = 3'd2,
        CFG_COEFF_A    = 3'd3,
        CFG_COEFF_B    = 3'd4
    } t_cfg_idx;

    localparam logic [15:0] REFL_RESET    = 16'd32768;
    localparam logic [15:0] COEFF_A_RESET = 16'd25706;
    localparam logic [15:0] COEFF_B_RESET = 16'd10842;

    localparam logic [14:0] INV_PI_Q16 = 15'd20861;
    localparam int          Y_CAP_LOG  = 40;
    localparam int          P_CAP_LOG  = 48;
    localparam logic [15:0] OUT_MAX    = 16'hFFFF;

    // side data riding through the square root stages
    typedef struct packed {
        logic               hz;
        logic [1:0]         zf;
        logic               sel;
        logic [14:0]        zb;
        logic signed [32:0] dot;
    } t_sq_side;

    typedef struct packed {
        logic hz;
        logic az_en;
        logic sat;
    } t_dv_flags;

endpackage

// File: design/oren_nayar_brdf_eval.sv
// Channel  Dir  Handshake                     Beat
// in       in   i_in_valid / o_in_ready       i_in_data  (onb_pkg::t_in)
// out      out  o_out_valid / i_out_ready     o_out_data (onb_pkg::t_out)
// cfg      in   i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One beat per cycle in and out while the output is not stalled. The pipeline
// holds the bit-per-stage square root (DIR_FRAC_BITS stages) and the bit-per-stage
// tangent divider (DIR_FRAC_BITS + 16 stages).
// Synchronous active-low reset clears valid bits and loads register defaults.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module oren_nayar_brdf_eval #(
    parameter int DIR_FRAC_BITS = 14
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  onb_pkg::t_in                     i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output onb_pkg::t_out                    o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [onb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [15:0]                      i_cfg_data
);

    localparam int F   = DIR_FRAC_BITS;
    localparam int RW  = 2 * F;
    localparam int CW  = (RW + 1 > 32) ? RW + 1 : 32;
    localparam int DW  = (RW > 32) ? RW : 32;
    localparam int TW  = F + 16;
    localparam int ND  = TW;
    localparam int GW  = 17;
    localparam int TL  = (TW + 1) / 2;
    localparam int XW  = TW + 1;
    localparam int XL  = (XW + 1) / 2;
    localparam int YW  = onb_pkg::Y_CAP_LOG + 1;
    localparam int YFW = (XW + 1 > YW) ? XW + 1 : YW;
    localparam int YL  = (YW + 1) / 2;
    localparam int PW  = 16 + YW;
    localparam int PL  = onb_pkg::P_CAP_LOG / 2;

    localparam logic [CW-1:0]  SS    = {{(CW-1){1'b0}}, 1'b1} << RW;
    localparam logic [YFW-1:0] Y_CAP = {{(YFW-1){1'b0}}, 1'b1} << onb_pkg::Y_CAP_LOG;

    // config registers
    logic [15:0] r_refl [3];
    logic [15:0] r_coeff_a;
    logic [15:0] r_coeff_b;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refl[0] <= onb_pkg::REFL_RESET;
            r_refl[1] <= onb_pkg::REFL_RESET;
            r_refl[2] <= onb_pkg::REFL_RESET;
            r_coeff_a <= onb_pkg::COEFF_A_RESET;
            r_coeff_b <= onb_pkg::COEFF_B_RESET;
        end else if (i_cfg_valid) begin
            unique case (onb_pkg::t_cfg_idx'(i_cfg_index))
                onb_pkg::CFG_REFL_RED:   r_refl[0] <= i_cfg_data;
                onb_pkg::CFG_REFL_GREEN: r_refl[1] <= i_cfg_data;
                onb_pkg::CFG_REFL_BLUE:  r_refl[2] <= i_cfg_data;
                onb_pkg::CFG_COEFF_A:    r_coeff_a <= i_cfg_data;
                onb_pkg::CFG_COEFF_B:    r_coeff_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_out_v;
    logic w_en;

    assign w_en        = !r_out_v || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_out_v;

    // ---------------- stage 0: squares, dot product
    logic signed [15:0] zi, zo;
    logic [31:0]        zz [2];
    logic signed [31:0] m1, m2;
    onb_pkg::t_sq_side  n_s0_side;
    logic [RW-1:0]      n_s0_rad [2];

    assign zi = i_in_data.in_dir_z;
    assign zo = i_in_data.out_dir_z;
    assign zz[0] = zi * zi;
    assign zz[1] = zo * zo;
    assign m1 = i_in_data.in_dir_x * i_in_data.out_dir_x;
    assign m2 = i_in_data.in_dir_y * i_in_data.out_dir_y;

    always_comb begin
        n_s0_side.hz  = (zo <= 16'sd0) || (zi <= 16'sd0);
        n_s0_side.sel = zi > zo;
        n_s0_side.zb  = n_s0_side.sel ? zi[14:0] : zo[14:0];
        n_s0_side.dot = 33'(m1) + 33'(m2);
        for (int s = 0; s < 2; s++) begin
            n_s0_side.zf[s] = CW'(zz[s]) >= SS;
            n_s0_rad[s]     = RW'(SS - CW'(zz[s]));
        end
    end

    // square root pipeline, index 0 is the input register
    logic [RW-1:0]     r_sq_rem  [F+1][2];
    logic [F-1:0]      r_sq_root [F+1][2];
    onb_pkg::t_sq_side r_sq_side [F+1];
    logic              r_sq_v    [F+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (w_en) begin
            r_sq_v[0] <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_side[0]    <= n_s0_side;
            r_sq_rem[0][0]  <= n_s0_rad[0];
            r_sq_rem[0][1]  <= n_s0_rad[1];
            r_sq_root[0][0] <= '0;
            r_sq_root[0][1] <= '0;
        end
    end

    for (genvar j = 0; j < F; j++) begin : g_sq
        localparam int K = F - 1 - j;
        logic [RW:0]   trial [2];
        logic          ge    [2];
        logic [RW-1:0] n_rem [2];
        logic [F-1:0]  n_root [2];

        always_comb begin
            for (int s = 0; s < 2; s++) begin
                trial[s] = ((RW+1)'(r_sq_root[j][s]) << (K + 1))
                         | ((RW+1)'(1) << (2 * K));
                ge[s]     = {1'b0, r_sq_rem[j][s]} >= trial[s];
                n_rem[s]  = ge[s] ? RW'({1'b0, r_sq_rem[j][s]} - trial[s]) : r_sq_rem[j][s];
                n_root[s] = ge[s] ? (r_sq_root[j][s] | (F'(1) << K)) : r_sq_root[j][s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[j+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_v[j+1] <= r_sq_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_side[j+1]    <= r_sq_side[j];
                r_sq_rem[j+1][0]  <= n_rem[0];
                r_sq_rem[j+1][1]  <= n_rem[1];
                r_sq_root[j+1][0] <= n_root[0];
                r_sq_root[j+1][1] <= n_root[1];
            end
        end
    end

    // ---------------- stage B: sines, denominator, selection
    logic [F-1:0]  sin_v [2];
    logic [RW-1:0] n_b_den;
    logic          n_b_az_en;

    logic          r_b_v, r_b_hz, r_b_az_en;
    logic [RW-1:0] r_b_den;
    logic [31:0]   r_b_dot;
    logic [F-1:0]  r_b_sa, r_b_sb;
    logic [14:0]   r_b_zb;

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            sin_v[s] = r_sq_side[F].zf[s] ? '0 : r_sq_root[F][s];
        end
        n_b_den   = sin_v[0] * sin_v[1];
        n_b_az_en = (sin_v[0] > F'(1)) && (sin_v[1] > F'(1))
                 && (r_sq_side[F].dot > 33'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_en) begin
            r_b_v <= r_sq_v[F];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_hz    <= r_sq_side[F].hz;
            r_b_az_en <= n_b_az_en;
            r_b_den   <= n_b_den;
            r_b_dot   <= r_sq_side[F].dot[31:0];
            r_b_sa    <= r_sq_side[F].sel ? sin_v[1] : sin_v[0];
            r_b_sb    <= r_sq_side[F].sel ? sin_v[0] : sin_v[1];
            r_b_zb    <= r_sq_side[F].zb;
        end
    end

    // ---------------- divider pipeline, index 0 is the set-up register
    logic [RW-1:0]      r_dv_ar  [ND+1];
    logic [F-1:0]       r_dv_aq  [ND+1];
    logic [14:0]        r_dv_tr  [ND+1];
    logic [TW-1:0]      r_dv_tq  [ND+1];
    logic [RW-1:0]      r_dv_den [ND+1];
    logic [F-1:0]       r_dv_sa  [ND+1];
    logic [F-1:0]       r_dv_sb  [ND+1];
    logic [14:0]        r_dv_zb  [ND+1];
    onb_pkg::t_dv_flags r_dv_fl  [ND+1];
    logic               r_dv_v   [ND+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_v[0] <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_ar[0]        <= RW'(r_b_dot);
            r_dv_aq[0]        <= '0;
            r_dv_tr[0]        <= '0;
            r_dv_tq[0]        <= '0;
            r_dv_den[0]       <= r_b_den;
            r_dv_sa[0]        <= r_b_sa;
            r_dv_sb[0]        <= r_b_sb;
            r_dv_zb[0]        <= r_b_zb;
            r_dv_fl[0].hz     <= r_b_hz;
            r_dv_fl[0].az_en  <= r_b_az_en;
            r_dv_fl[0].sat    <= DW'(r_b_dot) >= DW'(r_b_den);
        end
    end

    for (genvar j = 0; j < ND; j++) begin : g_dv
        localparam int NI = TW - 1 - j;
        logic [RW-1:0] n_ar;
        logic [F-1:0]  n_aq;
        logic          nb;
        logic [15:0]   t2;
        logic          tge;

        if (j < F) begin : g_az
            logic [RW:0] a2;
            logic        age;
            always_comb begin
                a2   = {r_dv_ar[j], 1'b0};
                age  = a2 >= {1'b0, r_dv_den[j]};
                n_ar = age ? RW'(a2 - {1'b0, r_dv_den[j]}) : RW'(a2);
                n_aq = {r_dv_aq[j][F-2:0], age};
            end
        end else begin : g_az_hold
            assign n_ar = r_dv_ar[j];
            assign n_aq = r_dv_aq[j];
        end

        if (NI >= 16) begin : g_nb
            assign nb = r_dv_sb[j][NI-16];
        end else begin : g_nb_zero
            assign nb = 1'b0;
        end

        assign t2  = {r_dv_tr[j], nb};
        assign tge = t2 >= {1'b0, r_dv_zb[j]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_ar[j+1]  <= n_ar;
                r_dv_aq[j+1]  <= n_aq;
                r_dv_tr[j+1]  <= tge ? 15'(t2 - {1'b0, r_dv_zb[j]}) : t2[14:0];
                r_dv_tq[j+1]  <= {r_dv_tq[j][TW-2:0], tge};
                r_dv_den[j+1] <= r_dv_den[j];
                r_dv_sa[j+1]  <= r_dv_sa[j];
                r_dv_sb[j+1]  <= r_dv_sb[j];
                r_dv_zb[j+1]  <= r_dv_zb[j];
                r_dv_fl[j+1]  <= r_dv_fl[j];
            end
        end
    end

    // ---------------- stage D: azimuth cosine times sin alpha
    logic [F:0]    azcos;
    logic          r_d_v, r_d_hz;
    logic [RW:0]   r_d_prod;
    logic [TW-1:0] r_d_tan;

    always_comb begin
        if (!r_dv_fl[ND].az_en) begin
            azcos = '0;
        end else if (r_dv_fl[ND].sat) begin
            azcos = (F+1)'(1) << F;
        end else begin
            azcos = {1'b0, r_dv_aq[ND]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (w_en) begin
            r_d_v <= r_dv_v[ND];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_hz   <= r_dv_fl[ND].hz;
            r_d_prod <= azcos * (RW+1)'(r_dv_sa[ND]);
            r_d_tan  <= r_dv_tq[ND];
        end
    end

    // ---------------- stage E: g to Q16, partial products with tan beta
    logic [F:0]       gq;
    logic [GW-1:0]    g;
    logic             r_e_v, r_e_hz;
    logic [GW+TL-1:0] r_e_pl;
    logic [GW+TW-TL-1:0] r_e_ph;

    assign gq = r_d_prod[RW:F];

    if (F >= 16) begin : g_scale_dn
        assign g = GW'(gq >> (F - 16));
    end else begin : g_scale_up
        assign g = GW'({gq, {(16-F){1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (w_en) begin
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_hz <= r_d_hz;
            r_e_pl <= (GW+TL)'(g) * (GW+TL)'(r_d_tan[TL-1:0]);
            r_e_ph <= (GW+TW-TL)'(g) * (GW+TW-TL)'(r_d_tan[TW-1:TL]);
        end
    end

    // ---------------- stage X: x = g * tan >> 16
    logic [GW+TW-1:0] xs;
    logic             r_x_v, r_x_hz;
    logic [XW-1:0]    r_x;

    assign xs = ((GW+TW)'(r_e_ph) << TL) + (GW+TW)'(r_e_pl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_v <= 1'b0;
        end else if (w_en) begin
            r_x_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x_hz <= r_e_hz;
            r_x    <= xs[GW+TW-1:16];
        end
    end

    // ---------------- stage G: B times x, partial products
    logic                r_g_v, r_g_hz;
    logic [16+XL-1:0]    r_g_bl;
    logic [16+XW-XL-1:0] r_g_bh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (w_en) begin
            r_g_v <= r_x_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_hz <= r_x_hz;
            r_g_bl <= (16+XL)'(r_coeff_b) * (16+XL)'(r_x[XL-1:0]);
            r_g_bh <= (16+XW-XL)'(r_coeff_b) * (16+XW-XL)'(r_x[XW-1:XL]);
        end
    end

    // ---------------- stage Y: y = A + (B*x >> 16), capped
    logic [16+XW-1:0] bs;
    logic [YFW-1:0]   yf;
    logic             r_y_v, r_y_hz;
    logic [YW-1:0]    r_y;

    assign bs = ((16+XW)'(r_g_bh) << XL) + (16+XW)'(r_g_bl);
    assign yf = YFW'(r_coeff_a) + YFW'(bs[16+XW-1:16]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_v <= 1'b0;
        end else if (w_en) begin
            r_y_v <= r_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_y_hz <= r_g_hz;
            r_y    <= (yf > Y_CAP) ? YW'(Y_CAP) : YW'(yf);
        end
    end

    // ---------------- stage I: refl * y, partial products
    logic                r_i_v, r_i_hz;
    logic [16+YL-1:0]    r_i_pl [3];
    logic [16+YW-YL-1:0] r_i_ph [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_v <= 1'b0;
        end else if (w_en) begin
            r_i_v <= r_y_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_i_hz <= r_y_hz;
            for (int c = 0; c < 3; c++) begin
                r_i_pl[c] <= (16+YL)'(r_refl[c]) * (16+YL)'(r_y[YL-1:0]);
                r_i_ph[c] <= (16+YW-YL)'(r_refl[c]) * (16+YW-YL)'(r_y[YW-1:YL]);
            end
        end
    end

    // ---------------- stage J: p and its cap
    logic [PW-1:0]                  psum [3];
    logic                           r_j_v, r_j_hz;
    logic [onb_pkg::P_CAP_LOG-1:0]  r_j_p    [3];
    logic                           r_j_psat [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            psum[c] = (PW'(r_i_ph[c]) << YL) + PW'(r_i_pl[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_v <= 1'b0;
        end else if (w_en) begin
            r_j_v <= r_i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_j_hz <= r_i_hz;
            for (int c = 0; c < 3; c++) begin
                r_j_p[c]    <= psum[c][onb_pkg::P_CAP_LOG-1:0];
                r_j_psat[c] <= |psum[c][PW-1:onb_pkg::P_CAP_LOG];
            end
        end
    end

    // ---------------- stage K: times 1/pi, partial products
    logic        r_k_v, r_k_hz;
    logic [38:0] r_k_ml   [3];
    logic [38:0] r_k_mh   [3];
    logic        r_k_psat [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_v <= 1'b0;
        end else if (w_en) begin
            r_k_v <= r_j_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k_hz <= r_j_hz;
            for (int c = 0; c < 3; c++) begin
                r_k_ml[c]   <= 39'(r_j_p[c][PL-1:0]) * 39'(onb_pkg::INV_PI_Q16);
                r_k_mh[c]   <= 39'(r_j_p[c][2*PL-1:PL]) * 39'(onb_pkg::INV_PI_Q16);
                r_k_psat[c] <= r_j_psat[c];
            end
        end
    end

    // ---------------- output: round, saturate
    logic [63:0]   vs  [3];
    logic [15:0]   val [3];
    onb_pkg::t_out n_out;
    onb_pkg::t_out r_out;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            vs[c] = (64'(r_k_mh[c]) << PL) + 64'(r_k_ml[c]) + (64'(1) << 33);
            if (r_k_hz) begin
                val[c] = '0;
            end else if (r_k_psat[c] || (vs[c][63:34] > 30'(onb_pkg::OUT_MAX))) begin
                val[c] = onb_pkg::OUT_MAX;
            end else begin
                val[c] = vs[c][49:34];
            end
        end
        n_out.value_red   = val[0];
        n_out.value_green = val[1];
        n_out.value_blue  = val[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r_k_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

`ifndef NO_ASSERTIONS
    a_horizon_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_k_v && r_k_hz) |=> (o_out_valid && (o_out_data == '0)))
        else $error("horizon beat gave non-zero value");

    a_tan_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_v[ND] && !r_dv_fl[ND].hz) |-> (r_dv_tr[ND] < r_dv_zb[ND]))
        else $error("tangent divider remainder not below divisor");

    a_sqrt_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sq_v[F] && !r_sq_side[F].hz && !r_sq_side[F].zf[0])
        |-> ({1'b0, r_sq_rem[F][0]} <= ((RW+1)'(r_sq_root[F][0]) << 1)))
        else $error("square root not floored");
`endif

endmodule
